[sv/wom_pkg.sv]
// Package for the wavetable oscillator mixer: widths, function codes,
// queue entry type and the default parameter values. No dependencies.
`default_nettype none
package wom_pkg;
	localparam int NUM_OSC_DEF = 8;
	localparam int TABLE_LEN_DEF = 1024;
	localparam int RATE_HZ_DEF = 48000;
	localparam int PHASE_FRAC_BITS_DEF = 16;
	localparam int NUM_TABLES = 9;
	localparam int OUT_W = 20;

	typedef enum logic [1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_SET  = 2'd1,
		FUNC_TICK = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	// One classified item as it travels from front to back
	typedef struct packed {
		func_t       func;
		logic [3:0]  waveform;
		logic [9:0]  table_index;
		logic [15:0] table_value;
		logic [2:0]  osc_index;
		logic [23:0] freq_hz;
		logic [15:0] amp;
		logic [15:0] pan_left;
		logic [15:0] pan_right;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_MUL1,
		ST_MUL2,
		ST_ACC,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

[sv/wom_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module wom_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[sv/wom_front.sv]
// Front part: accepts items, drops those with no effect and queues the
// rest for the back part. Depends on wom_pkg.
`default_nettype none
module wom_front #(
	parameter int DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire wom_pkg::cmd_t  cmd,
	output logic                q_valid,
	output wom_pkg::cmd_t       q_cmd,
	input  wire logic           q_take
);
	import wom_pkg::*;
	localparam int AW = $clog2(DEPTH);

	cmd_t          slot_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          keep, acc;

	// Classify: unused function code is dropped here
	assign keep = cmd.func != FUNC_NONE;
	assign full = cnt_q == (AW+1)'(DEPTH);
	assign acc = push && !full;
	assign q_valid = cnt_q != '0;
	assign q_cmd = slot_q[rd_q];

	// Hold queued items
	always_ff @(posedge clk) begin
		if (acc && keep) slot_q[wr_q] <= cmd;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (acc && keep) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (q_take && q_valid) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(acc && keep) - (AW+1)'(q_take && q_valid);
		end
	end
endmodule
`default_nettype wire

[sv/wom_back.sv]
// Back part: executes loads, sets (with a reciprocal-multiply step divider) and
// ticks (one oscillator per pass). Depends on wom_pkg and wom_ram.
`default_nettype none
module wom_back #(
	parameter int NUM_OSC = 8,
	parameter int TABLE_LEN = 1024,
	parameter int RATE_HZ = 48000,
	parameter int PHASE_FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire wom_pkg::cmd_t               q_cmd,
	output logic                             q_take,
	output logic                             res_valid,
	output logic signed [wom_pkg::OUT_W-1:0] res_left,
	output logic signed [wom_pkg::OUT_W-1:0] res_right,
	input  wire logic                        res_take
);
	import wom_pkg::*;
	localparam int TW = $clog2(TABLE_LEN);
	localparam int PW = TW + PHASE_FRAC_BITS;
	localparam int OW = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
	localparam int MW = (NUM_TABLES * TABLE_LEN > 1) ? $clog2(NUM_TABLES * TABLE_LEN) : 1;
	// dividend freq << (TW + PHASE_FRAC_BITS - 8)
	localparam int NW = 24 + TW + PHASE_FRAC_BITS - 8;
	localparam int RW = $clog2(RATE_HZ) + 1;
	// reciprocal of the rate scaled by 2^NW, and its width
	localparam longint unsigned RECIP = (64'd1 << NW) / 64'(RATE_HZ);
	localparam int KW = NW - $clog2(RATE_HZ) + 1;
	localparam int NCW = 2;
	localparam int SW = 16 + 16 + 17 + OW + 1;

	state_t state_q, state_d;

	logic [3:0]    wav_q  [NUM_OSC];
	logic [PW-1:0] step_q [NUM_OSC];
	logic [15:0]   amp_q  [NUM_OSC];
	logic [15:0]   gl_q   [NUM_OSC];
	logic [15:0]   gr_q   [NUM_OSC];
	logic [PW-1:0] ph_q   [NUM_OSC];

	logic [NW-1:0]  num_q;
	logic [KW-1:0]  qe_q;
	logic [KW+RW:0] prod_q;
	logic [NCW-1:0] bit_q;
	logic [OW-1:0]  o_q;
	logic           sil_q;
	logic signed [32:0] sa_s2;
	logic signed [49:0] pl_s3, pr_s3;
	logic signed [SW-1:0] suml_q, sumr_q;

	logic            we;
	logic [MW-1:0]   waddr, raddr;
	logic [15:0]     rdata;
	logic [24+KW-1:0] fm;
	logic [KW:0]     qn;
	logic [KW+RW:0]  prod_d;
	logic [PW:0]     ph_sum;
	logic            last_osc;

	wom_ram #(.WIDTH(16), .DEPTH(NUM_TABLES * TABLE_LEN)) u_tab (
		.clk(clk), .we(we), .waddr(waddr), .wdata(q_cmd.table_value),
		.raddr(raddr), .rdata(rdata)
	);

	// Table write address for loads; table read address for the current oscillator
	assign we = state_q == ST_IDLE && q_valid && q_cmd.func == FUNC_LOAD &&
		q_cmd.waveform < 4'(NUM_TABLES) && 32'(q_cmd.table_index) < 32'(TABLE_LEN);
	assign waddr = MW'(32'(q_cmd.waveform) * 32'(TABLE_LEN) + 32'(q_cmd.table_index));
	assign raddr = MW'(32'(wav_q[o_q]) * 32'(TABLE_LEN) + 32'(ph_q[o_q][PW-1:PHASE_FRAC_BITS]));
	assign last_osc = o_q == OW'(NUM_OSC - 1);

	// Step division by the rate: reciprocal estimate, then one correction
	assign fm = {{KW{1'b0}}, q_cmd.freq_hz} * {{24{1'b0}}, KW'(RECIP)};
	assign qn = {1'b0, qe_q} + (KW+1)'(1);
	assign prod_d = {{RW{1'b0}}, qn} * {{(KW+1){1'b0}}, RW'(RATE_HZ)};
	assign ph_sum = {1'b0, ph_q[o_q]} + {1'b0, step_q[o_q]};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && q_cmd.func == FUNC_SET && 32'(q_cmd.osc_index) < 32'(NUM_OSC))
					state_d = ST_DIV;
				else if (q_valid && q_cmd.func == FUNC_TICK) state_d = ST_RD;
			end
			ST_DIV:  if (bit_q == NCW'(1)) state_d = ST_IDLE;
			ST_RD:   state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_ACC;
			ST_ACC:  state_d = last_osc ? ST_OUT : ST_RD;
			ST_OUT:  if (!res_valid) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: retire the queue head when its work is done
	always_comb begin
		q_take = 1'b0;
		case (state_q)
			ST_IDLE: q_take = q_valid && !(q_cmd.func == FUNC_SET &&
				32'(q_cmd.osc_index) < 32'(NUM_OSC)) && q_cmd.func != FUNC_TICK;
			ST_DIV:  q_take = bit_q == NCW'(1);
			ST_OUT:  q_take = !res_valid;
			default: q_take = 1'b0;
		endcase
	end

	// Multiply pipeline for the current oscillator
	always_ff @(posedge clk) begin
		sa_s2  <= (sil_q ? 16'sd0 : $signed(rdata)) * $signed({1'b0, amp_q[o_q]});
		pl_s3  <= sa_s2 * $signed({1'b0, gl_q[o_q]});
		pr_s3  <= sa_s2 * $signed({1'b0, gr_q[o_q]});
	end

	// Control, oscillator state and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid <= 1'b0;
			o_q <= '0;
			sil_q <= 1'b0;
			bit_q <= '0;
			qe_q <= '0;
			prod_q <= '0;
			num_q <= '0;
			suml_q <= '0;
			sumr_q <= '0;
			res_left <= '0;
			res_right <= '0;
			for (int i = 0; i < NUM_OSC; i++) begin
				wav_q[i] <= '0; step_q[i] <= '0; amp_q[i] <= '0;
				gl_q[i] <= '0; gr_q[i] <= '0; ph_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (res_valid && res_take) res_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					num_q <= NW'({q_cmd.freq_hz, {(TW + PHASE_FRAC_BITS - 8){1'b0}}});
					bit_q <= NCW'(3);
					o_q <= '0;
					suml_q <= '0;
					sumr_q <= '0;
				end
				ST_DIV: begin
					bit_q <= bit_q - 1'b1;
					// estimate, then form the product that checks it
					if (bit_q == NCW'(3)) qe_q <= fm[24+KW-1:24];
					if (bit_q == NCW'(2)) prod_q <= prod_d;
					if (bit_q == NCW'(1)) begin
						wav_q[OW'(q_cmd.osc_index)] <= q_cmd.waveform;
						// modulus is a power of two: keep the low bits
						step_q[OW'(q_cmd.osc_index)] <=
							PW'(((KW+RW+1)'(num_q) >= prod_q) ? qn : {1'b0, qe_q});
						amp_q[OW'(q_cmd.osc_index)] <= q_cmd.amp;
						gl_q[OW'(q_cmd.osc_index)] <= q_cmd.pan_left;
						gr_q[OW'(q_cmd.osc_index)] <= q_cmd.pan_right;
					end
				end
				ST_RD: sil_q <= wav_q[o_q] >= 4'(NUM_TABLES);
				ST_ACC: begin
					suml_q <= suml_q + SW'(pl_s3);
					sumr_q <= sumr_q + SW'(pr_s3);
					ph_q[o_q] <= ph_sum[PW-1:0];
					if (!last_osc) o_q <= o_q + 1'b1;
				end
				ST_OUT: if (!res_valid) begin
					res_valid <= 1'b1;
					res_left <= sat(suml_q >>> 32);
					res_right <= sat(sumr_q >>> 32);
				end
				default: ;
			endcase
		end
	end

	// Clamp to the output range
	function automatic logic signed [OUT_W-1:0] sat(input logic signed [SW-1:0] v);
		if (v > SW'(524287)) return 20'sd524287;
		if (v < -SW'(524288)) return -20'sd524288;
		return v[OUT_W-1:0];
	endfunction
endmodule
`default_nettype wire

[sv/wavetable_oscillator_mixer.sv]
// Top level of the wavetable oscillator bank with stereo mix.
// Depends on wom_pkg, wom_front, wom_back (and wom_ram below it).
//
// Input channel: push/full with func and payload fields. Load items write
// one wave table entry; set items configure one oscillator; tick items
// produce one stereo frame on left_sample/right_sample (empty/pop).
// In the back part a load is finished in the idle state; a set passes
// through decode, reciprocal multiply, check product, and correct and write
// the step; a tick passes through table read, two multiplies and accumulate
// for each oscillator, then the output state.
// A 4-deep queue between front and back lets items arrive while the back
// part works. Reset clears all oscillator state; wave table contents are
// undefined until loaded. When the receiver holds pop low, the finished
// frame is held and the back part stalls on the next tick; the queue then
// fills and full rises.
`default_nettype none
module wavetable_oscillator_mixer #(
	parameter int NUM_OSC = wom_pkg::NUM_OSC_DEF,
	parameter int TABLE_LEN = wom_pkg::TABLE_LEN_DEF,
	parameter int RATE_HZ = wom_pkg::RATE_HZ_DEF,
	parameter int PHASE_FRAC_BITS = wom_pkg::PHASE_FRAC_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [1:0]                func,
	input  wire logic [3:0]                waveform,
	input  wire logic [9:0]                table_index,
	input  wire logic signed [15:0]        table_value,
	input  wire logic [2:0]                osc_index,
	input  wire logic [23:0]               freq_hz,
	input  wire logic [15:0]               amp,
	input  wire logic [15:0]               pan_left,
	input  wire logic [15:0]               pan_right,
	output logic                           empty,
	input  wire logic                      pop,
	output logic signed [wom_pkg::OUT_W-1:0] left_sample,
	output logic signed [wom_pkg::OUT_W-1:0] right_sample
);
	import wom_pkg::*;
	cmd_t in_cmd, q_cmd;
	logic q_valid, q_take, res_valid;

	assign in_cmd = '{func: func_t'(func), waveform: waveform, table_index: table_index,
		table_value: table_value, osc_index: osc_index, freq_hz: freq_hz, amp: amp,
		pan_left: pan_left, pan_right: pan_right};
	assign empty = !res_valid;

	wom_front #(.DEPTH(4)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(in_cmd),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take)
	);

	wom_back #(.NUM_OSC(NUM_OSC), .TABLE_LEN(TABLE_LEN), .RATE_HZ(RATE_HZ),
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take),
		.res_valid(res_valid), .res_left(left_sample), .res_right(right_sample),
		.res_take(pop)
	);
endmodule
`default_nettype wire

[sv/wom_checker.sv]
// Port-level checks for the wavetable oscillator mixer, bound to the top.
// Depends on nothing but the top level's ports.
`default_nettype none
module wom_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        push,
	input wire logic        full,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [19:0] left_sample,
	input wire logic [19:0] right_sample
);
	// A waiting item holds its value until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		empty == 1'b0 && !pop |=> empty == 1'b0 && $stable(left_sample)
		&& $stable(right_sample)) else $error("result changed while waiting");
	// A taken item is not shown again next cycle
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop |=> empty) else $error("result repeated");
	// No result is shown when reset is released
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result after reset");
	// An offered item always sees a defined full flag
	a_full_known: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !$isunknown(full)) else $error("full unknown while offered");
endmodule

bind wavetable_oscillator_mixer wom_checker u_chk (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full), .empty(empty),
	.pop(pop), .left_sample(left_sample), .right_sample(right_sample)
);
`default_nettype wire
